@@ rtl/cins_pkg.sv @@
// Shared constants, widths and command types for the column image scaler.
package cins_pkg;

  // Geometry of the kept window and of the rendered picture.
  localparam int WINDOW_BYTES = 4096;
  localparam int ROWS_PER_COL = 64;
  localparam int PICTURE_SIDE = 256;

  // Derived widths.
  localparam int PTR_W   = $clog2(WINDOW_BYTES);
  localparam int CNT_W   = PTR_W + 1;
  localparam int ROW_W   = $clog2(ROWS_PER_COL);
  localparam int COLS_W  = CNT_W - ROW_W;
  localparam int RS_LOG  = $clog2(PICTURE_SIDE);
  localparam int COORD_W = 8;
  localparam int DATA_W  = 8;
  localparam int SXP_W   = COORD_W + COLS_W;
  localparam int SX_W    = SXP_W - RS_LOG;
  localparam int SYP_W   = COORD_W + ROW_W + 1;
  localparam int SY_W    = SYP_W - RS_LOG;

  // Constants of the answer.
  localparam logic [DATA_W-1:0] GRAY_MAX = 8'd255;

  // Operation codes.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // write the incoming byte into the ring
    logic capture;  // latch the render coordinates
    logic map;      // scale the coordinates onto the column grid
    logic finish;   // form the gray level from the read word
  } cins_cmd_t;

endpackage

@@ rtl/cins_ram.sv @@
// Generic simple dual-port RAM with a registered read port.
module cins_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/cins_ctrl.sv @@
// Controller state machine that sequences loads and render requests.
module cins_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                operation,
  output logic                busy,
  output cins_pkg::cins_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MAP  = 2'd1;
  localparam logic [1:0] S_ADDR = 2'd2;
  localparam logic [1:0] S_READ = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Next state: loads finish in the accepting cycle, renders walk the read path.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && operation == cins_pkg::OP_RENDER) begin
          state_next = S_MAP;
        end
      end
      S_MAP:   state_next = S_ADDR;
      S_ADDR:  state_next = S_READ;
      S_READ:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Commands to the datapath.
  always_comb begin
    cmd.load    = accept && operation == cins_pkg::OP_LOAD;
    cmd.capture = accept && operation == cins_pkg::OP_RENDER;
    cmd.map     = (state == S_MAP);
    cmd.finish  = (state == S_READ);
  end

endmodule

@@ rtl/cins_datapath.sv @@
// Datapath: ring pointers, coordinate scaling, ring addressing and result word.
module cins_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  cins_pkg::cins_cmd_t                cmd,
  input  logic [cins_pkg::DATA_W-1:0]        data_byte,
  input  logic                               start_new,
  input  logic [cins_pkg::COORD_W-1:0]       pixel_x,
  input  logic [cins_pkg::COORD_W-1:0]       pixel_y,
  output logic [cins_pkg::DATA_W-1:0]        gray_level,
  output logic                               no_columns,
  output logic                               done
);

  logic [cins_pkg::PTR_W-1:0]   write_pointer;
  logic [cins_pkg::CNT_W-1:0]   kept_count;
  logic [cins_pkg::PTR_W-1:0]   wr_addr;
  logic [cins_pkg::COORD_W-1:0] px;
  logic [cins_pkg::COORD_W-1:0] py;
  logic [cins_pkg::COLS_W-1:0]  cols;
  logic [cins_pkg::SXP_W-1:0]   sx_prod;
  logic [cins_pkg::SYP_W-1:0]   sy_prod;
  logic [cins_pkg::SX_W-1:0]    sx_next;
  logic [cins_pkg::SY_W-1:0]    sy_next;
  logic [cins_pkg::COLS_W-1:0]  col;
  logic [cins_pkg::ROW_W-1:0]   row;
  logic                         blank;
  logic                         none;
  logic [cins_pkg::PTR_W-1:0]   oldest;
  logic [cins_pkg::PTR_W-1:0]   offset;
  logic [cins_pkg::PTR_W-1:0]   slot;
  logic [cins_pkg::DATA_W-1:0]  rdata;

  // A fresh image restarts the ring at slot zero.
  assign wr_addr = start_new ? '0 : write_pointer;

  // Ring pointer and saturating byte count.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      kept_count    <= '0;
    end else if (cmd.load) begin
      write_pointer <= wr_addr + 1'b1;
      if (start_new) begin
        kept_count <= cins_pkg::CNT_W'(1);
      end else if (kept_count < cins_pkg::CNT_W'(cins_pkg::WINDOW_BYTES)) begin
        kept_count <= kept_count + 1'b1;
      end
    end
  end

  // Full columns held; a trailing partial column drops out of the shift.
  assign cols = kept_count[cins_pkg::CNT_W-1:cins_pkg::ROW_W];

  // Nearest-neighbor scaling of the requested pixel onto the column grid.
  assign sx_prod = cins_pkg::SXP_W'(px) * cins_pkg::SXP_W'(cols);
  assign sy_prod = cins_pkg::SYP_W'(py) * cins_pkg::SYP_W'(cins_pkg::ROWS_PER_COL);
  assign sx_next = sx_prod[cins_pkg::SXP_W-1:cins_pkg::RS_LOG];
  assign sy_next = sy_prod[cins_pkg::SYP_W-1:cins_pkg::RS_LOG];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      px <= pixel_x;
      py <= pixel_y;
    end
    if (cmd.map) begin
      none  <= (cols == '0);
      blank <= (cins_pkg::COLS_W'(sx_next) >= cols) || (cols == '0)
               || (cins_pkg::CNT_W'(sy_next) >= cins_pkg::CNT_W'(cins_pkg::ROWS_PER_COL));
      // Columns are mirrored: the leftmost output column is the newest one.
      col   <= cols - 1'b1 - cins_pkg::COLS_W'(sx_next);
      row   <= sy_next[cins_pkg::ROW_W-1:0];
    end
  end

  // Ring slot of the chosen byte, counted from the oldest kept byte.
  assign oldest = write_pointer - kept_count[cins_pkg::PTR_W-1:0];
  assign offset = cins_pkg::PTR_W'(col) * cins_pkg::PTR_W'(cins_pkg::ROWS_PER_COL)
                  + cins_pkg::PTR_W'(row);
  assign slot   = oldest + offset;

  cins_ram #(
    .WIDTH (cins_pkg::DATA_W),
    .DEPTH (cins_pkg::WINDOW_BYTES)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (wr_addr),
    .wdata (data_byte),
    .raddr (slot),
    .rdata (rdata)
  );

  // Result word and its one-cycle strobe.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      gray_level <= blank ? cins_pkg::GRAY_MAX : cins_pkg::GRAY_MAX - rdata;
      no_columns <= none;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

endmodule

@@ rtl/column_image_nearest_scaler_top.sv @@
// Top level of the column image nearest-neighbor scaler.
// A load word is written when it is accepted and busy stays low, so loads can arrive every cycle.
// A render word holds busy high through its scale, address and ring read states; its result
// word shows on done as busy falls, and the next word may follow then.
// The result cannot be stalled: it is valid on gray_level and no_columns while done is high.
// Synchronous reset clears the byte count and ring pointer; ring contents are not cleared.
module column_image_nearest_scaler_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          operation,
  input  logic [cins_pkg::DATA_W-1:0]   data_byte,
  input  logic                          start_new,
  input  logic [cins_pkg::COORD_W-1:0]  pixel_x,
  input  logic [cins_pkg::COORD_W-1:0]  pixel_y,
  output logic                          done,
  output logic [cins_pkg::DATA_W-1:0]   gray_level,
  output logic                          no_columns
);

  cins_pkg::cins_cmd_t cmd;

  cins_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .busy      (busy),
    .cmd       (cmd)
  );

  cins_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .data_byte  (data_byte),
    .start_new  (start_new),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .gray_level (gray_level),
    .no_columns (no_columns),
    .done       (done)
  );

endmodule

@@ tb/sv/column_image_nearest_scaler_top_test.sv @@
// Self-checking testbench for the column image nearest-neighbor scaler top level.
`timescale 1ns / 100ps

module column_image_nearest_scaler_top_test;
  import cins_pkg::*;

  // One expected render answer.
  typedef struct packed {
    logic [DATA_W-1:0] gray;
    logic              none;
  } shade_t;

  // One row of the directed table. Load rows repeat reps times; with ramp set the byte
  // rises by one on each repeat. Typed rows carry their answer, the rest use the predictor.
  typedef struct {
    logic               op;
    logic [DATA_W-1:0]  data;
    logic               fresh;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    int                 reps;
    bit                 ramp;
    bit                 typed;
    logic [DATA_W-1:0]  gray;
    logic               none;
  } dir_row_t;

  localparam int DIR_ROWS     = 17;
  localparam int RANDOM_WORDS = 750;

  logic               clk;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               operation = OP_LOAD;
  logic [DATA_W-1:0]  data_byte = '0;
  logic               start_new = 1'b0;
  logic [COORD_W-1:0] pixel_x = '0;
  logic [COORD_W-1:0] pixel_y = '0;
  logic               done;
  logic [DATA_W-1:0]  gray_level;
  logic               no_columns;

  // Predictor state: the kept ring, its write slot and the saturating byte count.
  logic [DATA_W-1:0] ring_mem [WINDOW_BYTES];
  int unsigned       ring_wr = 0;
  int unsigned       ring_count = 0;

  shade_t pending_shades [$];
  int     mismatches = 0;
  bit     no_gaps = 1'b0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{OP_RENDER, 8'h00, 1'b0, 8'd0,   8'd0,   1, 1'b0, 1'b1, GRAY_MAX, 1'b1},
    '{OP_RENDER, 8'h00, 1'b1, 8'd255, 8'd255, 1, 1'b0, 1'b1, GRAY_MAX, 1'b1},
    '{OP_LOAD,   8'h00, 1'b1, 8'd0,   8'd0,   ROWS_PER_COL - 1, 1'b0, 1'b0, 8'h00, 1'b0},
    '{OP_RENDER, 8'h00, 1'b0, 8'd255, 8'd255, 1, 1'b0, 1'b1, GRAY_MAX, 1'b1},
    '{OP_LOAD,   8'h00, 1'b0, 8'd0,   8'd0,   1, 1'b0, 1'b0, 8'h00, 1'b0},
    '{OP_RENDER, 8'h00, 1'b0, 8'd0,   8'd0,   1, 1'b0, 1'b1, GRAY_MAX, 1'b0},
    '{OP_RENDER, 8'h00, 1'b0, 8'd255, 8'd255, 1, 1'b0, 1'b1, GRAY_MAX, 1'b0},
    '{OP_LOAD,   8'hFF, 1'b1, 8'd0,   8'd0,   ROWS_PER_COL, 1'b0, 1'b0, 8'h00, 1'b0},
    '{OP_RENDER, 8'h00, 1'b0, 8'd0,   8'd0,   1, 1'b0, 1'b1, 8'h00, 1'b0},
    '{OP_RENDER, 8'h00, 1'b0, 8'd255, 8'd128, 1, 1'b0, 1'b1, 8'h00, 1'b0},
    '{OP_LOAD,   8'h00, 1'b0, 8'd0,   8'd0,   ROWS_PER_COL, 1'b1, 1'b0, 8'h00, 1'b0},
    '{OP_RENDER, 8'h00, 1'b0, 8'd0,   8'd0,   1, 1'b0, 1'b0, 8'h00, 1'b0},
    '{OP_RENDER, 8'h00, 1'b0, 8'd255, 8'd255, 1, 1'b0, 1'b0, 8'h00, 1'b0},
    '{OP_RENDER, 8'h00, 1'b0, 8'd0,   8'd255, 1, 1'b0, 1'b0, 8'h00, 1'b0},
    '{OP_RENDER, 8'h00, 1'b1, 8'd128, 8'd100, 1, 1'b0, 1'b0, 8'h00, 1'b0},
    '{OP_LOAD,   8'h5A, 1'b1, 8'd0,   8'd0,   1, 1'b0, 1'b0, 8'h00, 1'b0},
    '{OP_RENDER, 8'h00, 1'b0, 8'd0,   8'd0,   1, 1'b0, 1'b1, GRAY_MAX, 1'b1}
  };

  column_image_nearest_scaler_top dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .operation  (operation),
    .data_byte  (data_byte),
    .start_new  (start_new),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .done       (done),
    .gray_level (gray_level),
    .no_columns (no_columns)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Predictor for a load: optional restart, then write at the ring slot and advance.
  task automatic store_pixel_byte(input logic [DATA_W-1:0] value, input logic fresh);
    if (fresh) begin
      ring_count = 0;
      ring_wr = 0;
    end
    ring_mem[ring_wr] = value;
    ring_wr = (ring_wr + 1) % WINDOW_BYTES;
    if (ring_count < WINDOW_BYTES) ring_count++;
  endtask

  // Predictor for a render: nearest-neighbor map with the newest column on the left.
  function automatic shade_t shade_of_pixel(input logic [COORD_W-1:0] px,
                                            input logic [COORD_W-1:0] py);
    int unsigned cols, sx, sy, col, oldest, slot;
    shade_t      s;
    cols = ring_count / ROWS_PER_COL;
    s.none = (cols == 0);
    s.gray = GRAY_MAX;
    if (cols != 0) begin
      sx = (int'(px) * cols) / PICTURE_SIDE;
      sy = (int'(py) * ROWS_PER_COL) / PICTURE_SIDE;
      if (sx < cols && sy < ROWS_PER_COL) begin
        col = cols - 1 - sx;
        oldest = (ring_wr + WINDOW_BYTES - ring_count) % WINDOW_BYTES;
        slot = (oldest + col * ROWS_PER_COL + sy) % WINDOW_BYTES;
        s.gray = GRAY_MAX - ring_mem[slot];
      end
    end
    return s;
  endfunction

  // Offer one word and hold it until the block takes it, then update the prediction.
  task automatic send_word(input logic op, input logic [DATA_W-1:0] data, input logic fresh,
                           input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
                           input bit use_typed, input shade_t typed_shade);
    start     <= 1'b1;
    operation <= op;
    data_byte <= data;
    start_new <= fresh;
    pixel_x   <= px;
    pixel_y   <= py;
    do @(posedge clk); while (busy);
    if (op == OP_RENDER) begin
      if (use_typed) pending_shades.push_back(typed_shade);
      else pending_shades.push_back(shade_of_pixel(px, py));
    end else begin
      store_pixel_byte(data, fresh);
    end
  endtask

  // Drop start for a gap of length n; zero leaves the next word back to back.
  task automatic idle_for(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Wait with start low until every outstanding render answer has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_shades.size() != 0) @(posedge clk);
  endtask

  // Mostly short gaps, a few long ones, none during a quiet stretch.
  function automatic int next_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (no_gaps || pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 20);
  endfunction

  // Coordinates lean toward the edges of the picture.
  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // Compare each result word against the oldest expected answer.
  always @(posedge clk) begin
    shade_t want;
    if (!rst && done) begin
      if (pending_shades.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result word: gray_level=%0d no_columns=%0b",
                   gray_level, no_columns);
      end else begin
        want = pending_shades.pop_front();
        if (gray_level !== want.gray || no_columns !== want.none) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: gray_level exp %0d got %0d, no_columns exp %0b got %0b",
                     want.gray, gray_level, want.none, no_columns);
        end
      end
    end
  end

  // Stimulus: reset, the directed table, then random images with render bursts.
  initial begin
    int          counted;
    int          n;
    int          big_fills;
    bit          big;
    bit          first;
    logic [DATA_W-1:0] value;

    counted = 0;
    big_fills = 0;
    first = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed rows: empty ring, partial column, first full column, restart, two columns.
    foreach (dir_rows[r]) begin
      for (int i = 0; i < dir_rows[r].reps; i++) begin
        value = dir_rows[r].ramp ? DATA_W'(dir_rows[r].data + i) : dir_rows[r].data;
        send_word(dir_rows[r].op, value, (i == 0) ? dir_rows[r].fresh : 1'b0,
                  dir_rows[r].px, dir_rows[r].py, dir_rows[r].typed,
                  '{gray: dir_rows[r].gray, none: dir_rows[r].none});
        idle_for(next_gap());
      end
    end
    drain_results();

    // Random part. The first image nearly fills or overfills the ring, so that it may wrap and
    // the count may saturate; bytes of such long fills do not count toward the word budget.
    while (counted < RANDOM_WORDS) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      big = 1'b0;
      if (first || $urandom_range(0, 5) == 0) begin
        if (first || ($urandom_range(0, 11) == 0 && big_fills < 3)) begin
          n = $urandom_range(WINDOW_BYTES - ROWS_PER_COL, WINDOW_BYTES + 600);
          big = 1'b1;
          big_fills++;
        end else begin
          n = $urandom_range(1, 320);
        end
        for (int i = 0; i < n; i++) begin
          send_word(OP_LOAD, DATA_W'($urandom), i == 0, pick_coord(), pick_coord(), 1'b0, '0);
          if (!big) counted++;
          idle_for(big ? 0 : next_gap());
        end
      end else begin
        // Append to the current image, now and then with a stray restart.
        n = $urandom_range(0, 40);
        for (int i = 0; i < n; i++) begin
          send_word(OP_LOAD, DATA_W'($urandom), $urandom_range(0, 49) == 0,
                    pick_coord(), pick_coord(), 1'b0, '0);
          counted++;
          idle_for(next_gap());
        end
      end
      first = 1'b0;

      // A burst of renders; start_new is random since a render ignores it.
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
        send_word(OP_RENDER, DATA_W'($urandom), 1'($urandom), pick_coord(), pick_coord(),
                  1'b0, '0);
        counted++;
        idle_for(next_gap());
      end
      if ($urandom_range(0, 19) == 0) drain_results();
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_shades.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
